### rtl/pwqm_pkg.sv
// ----------------------------------------------------------------------------
// pwqm_pkg
// Shared types and codes for the priority work queue matcher.
// ----------------------------------------------------------------------------
package pwqm_pkg;

    localparam logic [2:0] FN_APPEND = 3'd0;
    localparam logic [2:0] FN_DELETE = 3'd1;
    localparam logic [2:0] FN_SEQ    = 3'd2;
    localparam logic [2:0] FN_BEST   = 3'd3;
    localparam logic [2:0] FN_PIN    = 3'd4;
    localparam logic [2:0] FN_FIRST  = 3'd5;
    localparam logic [2:0] FN_AVAIL  = 3'd6;
    localparam logic [2:0] FN_UNUSED = 3'd7;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NONE  = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_BADH  = 2'd3;

    localparam logic [31:0] SIGN_BIAS   = 32'h8000_0000;
    localparam logic [31:0] UNTGT_FLOOR = 32'h8000_0000 - 32'd999999999;

    // entry word layout: type, prio, seq, target, pin rank, pinned, age
    localparam int ENTRY_W = 8 + 32 + 31 + 17 + 17 + 1 + 32;

    typedef struct packed {
        logic [7:0]  wtype;
        logic [31:0] prio;
        logic [30:0] seq;
        logic [16:0] tgt;
        logic [16:0] prank;
        logic        pin;
        logic [31:0] age;
    } t_entry;

    typedef struct packed {
        logic [2:0]  func;
        logic [7:0]  wtype;
        logic [31:0] prio;
        logic [30:0] seq;
        logic [16:0] tgt;
        logic [16:0] prank;
        logic        pin;
        logic [5:0]  handle;
        logic [3:0][8:0] req;
    } t_req;

    // controller -> datapath
    typedef struct packed {
        logic load;     // latch request, clear scan state
        logic scan;     // a memory word arrives this cycle
        logic do_write; // perform append/delete write
    } t_cmd;

endpackage

### rtl/priority_work_queue_matcher_core.sv
// The request is latched, every slot is swept, the append/delete write follows,
// then the result beat is presented; a new beat is accepted only after the result
// beat is taken. The sweep reads one entry-store word per cycle through one read port.
// Reset: synchronous active-low; clears valid bits and the arrival counter.
// Entry store contents are left undefined, masked by the valid bits.
// ----------------------------------------------------------------------------
// priority_work_queue_matcher_core
// Top level: sequencer plus scanning datapath.
// ----------------------------------------------------------------------------
module priority_work_queue_matcher_core #(
    parameter int QUEUE_DEPTH = 64,
    parameter int NUM_REQ     = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_func,
    input  logic [7:0]  i_work_type,
    input  logic [31:0] i_priority_req,
    input  logic [30:0] i_seqno,
    input  logic [16:0] i_target_rank,
    input  logic [16:0] i_pin_rank,
    input  logic        i_pinned,
    input  logic [5:0]  i_handle,
    input  logic [8:0]  i_req_type_0,
    input  logic [8:0]  i_req_type_1,
    input  logic [8:0]  i_req_type_2,
    input  logic [8:0]  i_req_type_3,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [5:0]  o_slot,
    output logic [7:0]  o_found_type,
    output logic [31:0] o_found_priority,
    output logic [30:0] o_found_seqno,
    output logic [16:0] o_found_target,
    output logic [6:0]  o_entry_count,
    output logic [6:0]  o_unpinned_count,
    output logic [6:0]  o_free_count
);
    import pwqm_pkg::*;

    t_cmd                           w_cmd;
    t_req                           w_req;
    logic [$clog2(QUEUE_DEPTH)-1:0] w_raddr;

    always_comb begin
        w_req.func   = i_func;
        w_req.wtype  = i_work_type;
        w_req.prio   = i_priority_req;
        w_req.seq    = i_seqno;
        w_req.tgt    = i_target_rank;
        w_req.prank  = i_pin_rank;
        w_req.pin    = i_pinned;
        w_req.handle = i_handle;
        // unused request slots never match
        w_req.req[0] = i_req_type_0;
        w_req.req[1] = (NUM_REQ > 1) ? i_req_type_1 : 9'h1FE;
        w_req.req[2] = (NUM_REQ > 2) ? i_req_type_2 : 9'h1FE;
        w_req.req[3] = (NUM_REQ > 3) ? i_req_type_3 : 9'h1FE;
    end

    pwqm_ctrl #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_raddr (w_raddr),
        .o_cmd   (w_cmd)
    );

    pwqm_dp #(.QUEUE_DEPTH(QUEUE_DEPTH), .NUM_REQ(NUM_REQ)) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_req            (w_req),
        .i_raddr          (w_raddr),
        .o_status         (o_status),
        .o_slot           (o_slot),
        .o_found_type     (o_found_type),
        .o_found_priority (o_found_priority),
        .o_found_seqno    (o_found_seqno),
        .o_found_target   (o_found_target),
        .o_entry_count    (o_entry_count),
        .o_unpinned_count (o_unpinned_count),
        .o_free_count     (o_free_count)
    );
endmodule

### rtl/pwqm_ram.sv
// ----------------------------------------------------------------------------
// pwqm_ram
// Generic single-port-write, single-read RAM with registered read.
// ----------------------------------------------------------------------------
module pwqm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### rtl/pwqm_ctrl.sv
// ----------------------------------------------------------------------------
// pwqm_ctrl
// Sequencer: accepts a request, sweeps memory addresses, then presents result.
// ----------------------------------------------------------------------------
module pwqm_ctrl #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [$clog2(QUEUE_DEPTH)-1:0] o_raddr,
    output pwqm_pkg::t_cmd                 o_cmd
);
    import pwqm_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_LAST, S_WR, S_OUT} t_state;

    t_state        r_state;
    logic [AW-1:0] r_addr;

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_raddr = r_addr;

    always_comb begin
        o_cmd.load     = (r_state == S_IDLE) && i_valid;
        o_cmd.scan     = (r_state == S_SCAN && r_addr != '0) || (r_state == S_LAST);
        // write once the sweep has settled the free slot
        o_cmd.do_write = (r_state == S_WR);
    end

    // data for address a arrives in the cycle after a is issued
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_addr  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_addr <= '0;
                    if (i_valid) begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_addr == AW'(QUEUE_DEPTH - 1)) begin
                        r_state <= S_LAST;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                S_LAST: r_state <= S_WR;
                S_WR:   r_state <= S_OUT;
                S_OUT: begin
                    if (!i_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

### rtl/pwqm_dp.sv
// ----------------------------------------------------------------------------
// pwqm_dp
// Datapath: entry store, valid bits, scan comparators, counters, result.
// ----------------------------------------------------------------------------
module pwqm_dp #(
    parameter int QUEUE_DEPTH = 64,
    parameter int NUM_REQ     = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  pwqm_pkg::t_cmd                 i_cmd,
    input  pwqm_pkg::t_req                 i_req,
    input  logic [$clog2(QUEUE_DEPTH)-1:0] i_raddr,
    output logic [1:0]                     o_status,
    output logic [5:0]                     o_slot,
    output logic [7:0]                     o_found_type,
    output logic [31:0]                    o_found_priority,
    output logic [30:0]                    o_found_seqno,
    output logic [16:0]                    o_found_target,
    output logic [6:0]                     o_entry_count,
    output logic [6:0]                     o_unpinned_count,
    output logic [6:0]                     o_free_count
);
    import pwqm_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_req            r_req;
    logic [QUEUE_DEPTH-1:0] r_valid;
    logic [31:0]     r_arrival;
    logic [AW-1:0]   r_scan_idx;  // slot of word arriving now
    logic            r_found;
    logic [AW-1:0]   r_fslot;
    t_entry          r_fent;
    logic            r_fent_valid;
    logic [31:0]     r_best;
    logic [31:0]     r_best_age;
    logic            r_free_ok;
    logic [AW-1:0]   r_free_slot;
    logic [CW-1:0]   r_cnt, r_unp, r_fre;
    t_entry          w_rd, w_wr;
    logic            w_we;
    logic [AW-1:0]   w_waddr;

    pwqm_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wr),
        .i_raddr (i_raddr),
        .o_rdata (w_rd)
    );

    // per-word match logic
    logic        v, hit, tie, tgt_neg, in_range;
    logic [31:0] p, key, fkey;
    always_comb begin
        v        = r_valid[r_scan_idx];
        p        = w_rd.prio ^ SIGN_BIAS;
        key      = w_rd.age - r_arrival;
        fkey     = r_best_age - r_arrival;
        tgt_neg  = w_rd.tgt[16];
        hit      = 1'b0;
        in_range = 1'b0;
        tie      = !r_found || (key < fkey);
        case (r_req.func)
            FN_SEQ:   hit = v && (w_rd.seq == r_req.seq) && tie;
            FN_PIN:   hit = v && (w_rd.prank == r_req.prank) && (w_rd.seq == r_req.seq)
                            && tie;
            FN_FIRST: hit = v && !w_rd.pin && tie;
            FN_BEST: begin
                for (int j = 0; j < NUM_REQ; j++) begin
                    if (r_req.req[j] == 9'h1FF || r_req.req[j] == {1'b0, w_rd.wtype}) begin
                        in_range = 1'b1;
                    end
                end
                hit = v && !w_rd.pin && in_range
                      && (r_req.tgt[16] ? tgt_neg : (w_rd.tgt == r_req.tgt))
                      && ((p > r_best) || (r_found && p == r_best && key < fkey));
            end
            FN_AVAIL: hit = v && !w_rd.pin && tgt_neg && (w_rd.wtype == r_req.wtype)
                            && (p > r_best);
            default:  hit = 1'b0;
        endcase
    end

    // write at end of sweep
    logic          w_del_ok;
    always_comb begin
        w_del_ok = (int'(r_req.handle) < QUEUE_DEPTH) && r_valid[r_req.handle[AW-1:0]];
        w_we    = i_cmd.do_write && r_req.func == FN_APPEND && r_free_ok;
        w_waddr = r_free_slot;
        w_wr.wtype = r_req.wtype;
        w_wr.prio  = r_req.prio;
        w_wr.seq   = r_req.seq;
        w_wr.tgt   = r_req.tgt;
        w_wr.prank = r_req.prank;
        w_wr.pin   = r_req.pin;
        w_wr.age   = r_arrival;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_arrival <= '0;
        end else if (i_cmd.do_write) begin
            if (w_we) begin
                r_valid[r_free_slot] <= 1'b1;
                r_arrival <= r_arrival + 1'b1;
            end else if (r_req.func == FN_DELETE && w_del_ok) begin
                r_valid[r_req.handle[AW-1:0]] <= 1'b0;
            end
        end
    end

    // result formation
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req      <= i_req;
            r_scan_idx <= '0;
            r_found    <= 1'b0;
            r_free_ok  <= 1'b0;
            r_free_slot <= '0;
            r_best     <= (i_req.func == FN_BEST && i_req.tgt[16]) ? UNTGT_FLOOR : 32'd0;
            r_cnt <= '0; r_unp <= '0; r_fre <= '0;
        end else if (i_cmd.scan) begin
            r_scan_idx <= r_scan_idx + 1'b1;
            if (!v && !r_free_ok) begin
                r_free_ok   <= 1'b1;
                r_free_slot <= r_scan_idx;
            end
            if (r_req.func == FN_DELETE && r_scan_idx == r_req.handle[AW-1:0]) begin
                r_fent <= w_rd;
            end
            if (hit) begin
                r_found    <= 1'b1;
                r_fslot    <= r_scan_idx;
                r_fent     <= w_rd;
                r_best     <= p;
                r_best_age <= w_rd.age;
            end
            if (v) begin
                r_cnt <= r_cnt + 1'b1;
                if (!w_rd.pin) begin
                    r_unp <= r_unp + 1'b1;
                    if (tgt_neg) r_fre <= r_fre + 1'b1;
                end
            end
        end
    end

    // final answer with counts adjusted for the write
    always_comb begin
        logic ok;
        ok = 1'b0;
        o_status = ST_NONE;
        o_slot = '0; o_found_type = '0; o_found_priority = '0;
        o_found_seqno = '0; o_found_target = '0;
        case (r_req.func) inside
            FN_APPEND: begin
                o_status = r_free_ok ? ST_OK : ST_FULL;
                if (r_free_ok) begin
                    o_slot = 6'(r_free_slot);
                    o_found_type = r_req.wtype; o_found_priority = r_req.prio;
                    o_found_seqno = r_req.seq; o_found_target = r_req.tgt;
                end
            end
            FN_DELETE: begin
                ok = r_fent_valid;
                o_status = ok ? ST_OK : ST_BADH;
                if (ok) begin
                    o_slot = r_req.handle;
                    o_found_type = r_fent.wtype; o_found_priority = r_fent.prio;
                    o_found_seqno = r_fent.seq; o_found_target = r_fent.tgt;
                end
            end
            FN_AVAIL: begin
                o_status = ST_OK;
                o_found_priority = r_best ^ SIGN_BIAS;
            end
            FN_SEQ, FN_BEST, FN_PIN, FN_FIRST: begin
                if (r_found) begin
                    o_status = ST_OK;
                    o_slot = 6'(r_fslot);
                    o_found_type = r_fent.wtype; o_found_priority = r_fent.prio;
                    o_found_seqno = r_fent.seq; o_found_target = r_fent.tgt;
                end
            end
            default: o_status = ST_NONE;
        endcase
        // append adds one; delete removes one
        o_entry_count    = 7'(r_cnt);
        o_unpinned_count = 7'(r_unp);
        o_free_count     = 7'(r_fre);
        if (r_req.func == FN_APPEND && r_free_ok) begin
            o_entry_count = 7'(r_cnt) + 7'd1;
            if (!r_req.pin) begin
                o_unpinned_count = 7'(r_unp) + 7'd1;
                if (r_req.tgt[16]) o_free_count = 7'(r_fre) + 7'd1;
            end
        end else if (r_req.func == FN_DELETE && ok) begin
            o_entry_count = 7'(r_cnt) - 7'd1;
            if (!r_fent.pin) begin
                o_unpinned_count = 7'(r_unp) - 7'd1;
                if (r_fent.tgt[16]) o_free_count = 7'(r_fre) - 7'd1;
            end
        end
    end

    // valid flag of the delete target, captured before it is cleared
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_fent_valid <= 1'b0;
        end else if (i_cmd.do_write && r_req.func == FN_DELETE) begin
            r_fent_valid <= w_del_ok;
        end
    end
endmodule
